[design/assert_macros.svh]
// assertion macros for the rtl files
// no dependencies; disabled as a whole by defining ASSERT_OFF
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
`define ASSERT_PROP(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("assertion failed");
`define ASSERT_NEVER(label, clk, rst_n, expr) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
		else $error("forbidden condition seen");
`else
`define ASSERT_PROP(label, clk, rst_n, prop)
`define ASSERT_NEVER(label, clk, rst_n, expr)
`endif

`endif

[design/lcd_pkg.sv]
// shared widths, register indexes and pipeline types of the line crossing detector
// no dependencies
package lcd_pkg;

	localparam int COORD_BITS    = 12;
	localparam int DIFF_BITS     = COORD_BITS + 1;
	localparam int PROD_BITS     = 2 * DIFF_BITS;
	localparam int SUM_BITS      = PROD_BITS + 1;
	localparam int TAG_BITS      = 16;
	localparam int HIST_BITS     = 8;
	localparam int LINE_REG_BITS = 12;
	localparam int CFG_IDX_BITS  = 3;
	localparam int CFG_DATA_BITS = 12;

	localparam logic [CFG_IDX_BITS-1:0] REG_LINE_START_X = 3'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_LINE_START_Y = 3'd1;
	localparam logic [CFG_IDX_BITS-1:0] REG_LINE_END_X   = 3'd2;
	localparam logic [CFG_IDX_BITS-1:0] REG_LINE_END_Y   = 3'd3;
	localparam logic [CFG_IDX_BITS-1:0] REG_MIN_HISTORY  = 3'd4;

	localparam logic [HIST_BITS-1:0] MIN_HISTORY_RST = 8'd2;

	typedef logic signed [DIFF_BITS-1:0] diff_t;
	typedef logic signed [PROD_BITS-1:0] prod_t;
	typedef logic signed [SUM_BITS-1:0]  sum_t;

	// sideband that travels with each item down the pipeline
	typedef struct packed {
		logic                valid;
		logic                eligible;
		logic [TAG_BITS-1:0] tag;
	} lcd_side_t;

endpackage

[design/line_crossing_detector_core.sv]
// top level of the line crossing detector: config registers and four-stage pipeline
// depends on lcd_pkg, lcd_delta, lcd_cross, lcd_judge and assert_macros.svh

// Tests each tracked object's motion step (previous centre to current
// centre) against a tripwire segment held in configuration registers and
// reports a crossing flag and its direction. The pipeline takes one item
// in every cycle: busy is always low, so a transaction is accepted at any
// edge with start high. Each result passes the side_s1, side_s2, side_s3
// and done registers, with done high for one cycle; results leave in
// order and the receiver cannot hold them off, so no stage ever stalls.
// The four stages are the coordinate differences, the signed cross
// products (one multiplier per product), the determinant and numerator
// subtractions, and the sign and magnitude range checks. Configuration
// writes are always accepted (cfg_ready high) and take effect for items
// accepted after the write; writes to an unknown index are dropped.
`include "assert_macros.svh"

module line_crossing_detector_core import lcd_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	// item transaction
	input  logic                     start,
	output logic                     busy,
	input  logic [TAG_BITS-1:0]      object_tag,
	input  logic                     alive,
	input  logic [HIST_BITS-1:0]     history_len,
	input  logic [COORD_BITS-1:0]    prev_x,
	input  logic [COORD_BITS-1:0]    prev_y,
	input  logic [COORD_BITS-1:0]    cur_x,
	input  logic [COORD_BITS-1:0]    cur_y,
	// result strobe
	output logic                     done,
	output logic [TAG_BITS-1:0]      tag_out,
	output logic                     crossed,
	output logic                     a_to_b,
	// configuration write transaction
	input  logic                     cfg_valid,
	output logic                     cfg_ready,
	input  logic [CFG_IDX_BITS-1:0]  cfg_index,
	input  logic [CFG_DATA_BITS-1:0] cfg_data
);

	// tripwire and eligibility registers
	logic [LINE_REG_BITS-1:0] line_start_x_q, line_start_y_q;
	logic [LINE_REG_BITS-1:0] line_end_x_q, line_end_y_q;
	logic [HIST_BITS-1:0]     min_history_q;

	lcd_side_t side_in, side_s1, side_s3;
	diff_t     ax_s1, ay_s1, bx_s1, by_s1, dx_s1, dy_s1, ux_s1, uy_s1;
	sum_t      det_s3, rn_s3, sn_s3, d1_s3;

	// no back-pressure anywhere in the pipeline
	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_start_x_q <= '0;
			line_start_y_q <= '0;
			line_end_x_q   <= '0;
			line_end_y_q   <= '0;
			min_history_q  <= MIN_HISTORY_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_LINE_START_X: line_start_x_q <= cfg_data[LINE_REG_BITS-1:0];
				REG_LINE_START_Y: line_start_y_q <= cfg_data[LINE_REG_BITS-1:0];
				REG_LINE_END_X:   line_end_x_q   <= cfg_data[LINE_REG_BITS-1:0];
				REG_LINE_END_Y:   line_end_y_q   <= cfg_data[LINE_REG_BITS-1:0];
				REG_MIN_HISTORY:  min_history_q  <= cfg_data[HIST_BITS-1:0];
				default: begin
					// unknown index, write dropped
				end
			endcase
		end
	end

	// eligibility is settled at entry so only one bit travels on
	always_comb begin
		side_in.valid    = start && !busy;
		side_in.eligible = alive && (history_len > min_history_q);
		side_in.tag      = object_tag;
	end

	lcd_delta u_delta (
		.clk     (clk),
		.arst_n  (arst_n),
		.side_in (side_in),
		.px      (prev_x),
		.py      (prev_y),
		.cx      (cur_x),
		.cy      (cur_y),
		.sx      (COORD_BITS'(line_start_x_q)),
		.sy      (COORD_BITS'(line_start_y_q)),
		.ex      (COORD_BITS'(line_end_x_q)),
		.ey      (COORD_BITS'(line_end_y_q)),
		.side_s1 (side_s1),
		.ax_s1   (ax_s1),
		.ay_s1   (ay_s1),
		.bx_s1   (bx_s1),
		.by_s1   (by_s1),
		.dx_s1   (dx_s1),
		.dy_s1   (dy_s1),
		.ux_s1   (ux_s1),
		.uy_s1   (uy_s1)
	);

	// products, then det = a x b, rn = d x b, sn = a x d, d1 = a x (cur - start)
	lcd_cross u_cross (
		.clk     (clk),
		.arst_n  (arst_n),
		.side_s1 (side_s1),
		.ax_s1   (ax_s1),
		.ay_s1   (ay_s1),
		.bx_s1   (bx_s1),
		.by_s1   (by_s1),
		.dx_s1   (dx_s1),
		.dy_s1   (dy_s1),
		.ux_s1   (ux_s1),
		.uy_s1   (uy_s1),
		.side_s3 (side_s3),
		.det_s3  (det_s3),
		.rn_s3   (rn_s3),
		.sn_s3   (sn_s3),
		.d1_s3   (d1_s3)
	);

	// crossing when both ratios lie in [0,1]; a to b when prev is on the
	// positive side and cur strictly on the negative side
	lcd_judge u_judge (
		.clk     (clk),
		.arst_n  (arst_n),
		.side_s3 (side_s3),
		.det_s3  (det_s3),
		.rn_s3   (rn_s3),
		.sn_s3   (sn_s3),
		.d1_s3   (d1_s3),
		.done    (done),
		.tag_out (tag_out),
		.crossed (crossed),
		.a_to_b  (a_to_b)
	);

	// every accepted item yields its result on done after the pipeline registers
	`ASSERT_PROP(a_latency, clk, arst_n, start && !busy |-> ##4 done)
	// an item that is not alive never reports a crossing
	`ASSERT_PROP(a_dead_no_cross, clk, arst_n, start && !busy && !alive |-> ##4 !crossed)
	// direction is only reported for a crossing
	`ASSERT_NEVER(a_dir_needs_cross, clk, arst_n, a_to_b && !crossed)

endmodule

[design/lcd_delta.sv]
// stage 1: coordinate differences of tripwire and motion segment
// depends on lcd_pkg
module lcd_delta import lcd_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  lcd_side_t             side_in,
	input  logic [COORD_BITS-1:0] px,
	input  logic [COORD_BITS-1:0] py,
	input  logic [COORD_BITS-1:0] cx,
	input  logic [COORD_BITS-1:0] cy,
	input  logic [COORD_BITS-1:0] sx,
	input  logic [COORD_BITS-1:0] sy,
	input  logic [COORD_BITS-1:0] ex,
	input  logic [COORD_BITS-1:0] ey,
	output lcd_side_t             side_s1,
	output diff_t                 ax_s1,
	output diff_t                 ay_s1,
	output diff_t                 bx_s1,
	output diff_t                 by_s1,
	output diff_t                 dx_s1,
	output diff_t                 dy_s1,
	output diff_t                 ux_s1,
	output diff_t                 uy_s1
);

	function automatic diff_t sub_u(input logic [COORD_BITS-1:0] a,
		input logic [COORD_BITS-1:0] b);
		return $signed({1'b0, a}) - $signed({1'b0, b});
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_s1 <= '0;
		end else begin
			side_s1 <= side_in;
		end
	end

	// tripwire direction, reversed motion, prev and cur relative to start
	always_ff @(posedge clk) begin
		ax_s1 <= sub_u(ex, sx);
		ay_s1 <= sub_u(ey, sy);
		bx_s1 <= sub_u(px, cx);
		by_s1 <= sub_u(py, cy);
		dx_s1 <= sub_u(px, sx);
		dy_s1 <= sub_u(py, sy);
		ux_s1 <= sub_u(cx, sx);
		uy_s1 <= sub_u(cy, sy);
	end

endmodule

[design/lcd_cross.sv]
// stages 2 and 3: cross products, then determinant and numerators
// depends on lcd_pkg
module lcd_cross import lcd_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  lcd_side_t side_s1,
	input  diff_t     ax_s1,
	input  diff_t     ay_s1,
	input  diff_t     bx_s1,
	input  diff_t     by_s1,
	input  diff_t     dx_s1,
	input  diff_t     dy_s1,
	input  diff_t     ux_s1,
	input  diff_t     uy_s1,
	output lcd_side_t side_s3,
	output sum_t      det_s3,
	output sum_t      rn_s3,
	output sum_t      sn_s3,
	output sum_t      d1_s3
);

	lcd_side_t side_s2;
	prod_t     ax_by_s2, ay_bx_s2, dx_by_s2, dy_bx_s2;
	prod_t     ax_dy_s2, ay_dx_s2, ax_uy_s2, ay_ux_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_s2 <= '0;
			side_s3 <= '0;
		end else begin
			side_s2 <= side_s1;
			side_s3 <= side_s2;
		end
	end

	always_ff @(posedge clk) begin
		ax_by_s2 <= prod_t'(ax_s1) * prod_t'(by_s1);
		ay_bx_s2 <= prod_t'(ay_s1) * prod_t'(bx_s1);
		dx_by_s2 <= prod_t'(dx_s1) * prod_t'(by_s1);
		dy_bx_s2 <= prod_t'(dy_s1) * prod_t'(bx_s1);
		ax_dy_s2 <= prod_t'(ax_s1) * prod_t'(dy_s1);
		ay_dx_s2 <= prod_t'(ay_s1) * prod_t'(dx_s1);
		ax_uy_s2 <= prod_t'(ax_s1) * prod_t'(uy_s1);
		ay_ux_s2 <= prod_t'(ay_s1) * prod_t'(ux_s1);
	end

	always_ff @(posedge clk) begin
		det_s3 <= SUM_BITS'(ax_by_s2) - SUM_BITS'(ay_bx_s2);
		rn_s3  <= SUM_BITS'(dx_by_s2) - SUM_BITS'(dy_bx_s2);
		sn_s3  <= SUM_BITS'(ax_dy_s2) - SUM_BITS'(ay_dx_s2);
		d1_s3  <= SUM_BITS'(ax_uy_s2) - SUM_BITS'(ay_ux_s2);
	end

endmodule

[design/lcd_judge.sv]
// stage 4: range checks without division, direction and result register
// depends on lcd_pkg
module lcd_judge import lcd_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  lcd_side_t           side_s3,
	input  sum_t                det_s3,
	input  sum_t                rn_s3,
	input  sum_t                sn_s3,
	input  sum_t                d1_s3,
	output logic                done,
	output logic [TAG_BITS-1:0] tag_out,
	output logic                crossed,
	output logic                a_to_b
);

	logic hit;

	// num/den within [0,1] for nonzero den; the caller excludes a den of zero
	function automatic logic in_unit(input sum_t num, input sum_t den);
		logic res;
		if (den > 0) begin
			res = (num >= 0) && (num <= den);
		end else begin
			res = (num <= 0) && (num >= den);
		end
		return res;
	endfunction

	assign hit = side_s3.eligible && (det_s3 != 0) &&
		in_unit(rn_s3, det_s3) && in_unit(sn_s3, det_s3);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done    <= 1'b0;
			tag_out <= '0;
			crossed <= 1'b0;
			a_to_b  <= 1'b0;
		end else begin
			done    <= side_s3.valid;
			tag_out <= side_s3.tag;
			crossed <= hit;
			a_to_b  <= hit && (sn_s3 > 0) && (d1_s3 < 0);
		end
	end

endmodule
